// ----- design/debug_abbrev_table_lookup_top_defines.svh -----
// Assertion macros shared by the abbreviation table lookup block.
// Included by the modules that carry concurrent assertions.
`ifndef DEBUG_ABBREV_TABLE_LOOKUP_TOP_DEFINES_SVH
`define DEBUG_ABBREV_TABLE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define DATL_ASSERT_IMP(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define DATL_ASSERT_NEXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);

`endif

// ----- design/datl_pkg.sv -----
// Types, codes and constants of the abbreviation table lookup block.
// Used by the controller, the datapath and the top level.
package datl_pkg;

  localparam int HINT_SLOTS_DEF  = 16;
  localparam int STORE_BYTES_DEF = 65536;
  localparam int BACKUP_REACH    = 20;
  localparam int OFFSET_CAP      = 65536;
  localparam int SECTION_END_RST = 65536;

  typedef enum logic [1:0] {
    K_LOAD   = 2'd0,
    K_BEGIN  = 2'd1,
    K_LOOKUP = 2'd2,
    K_ATTR   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HINT,
    S_SCODE,
    S_STAG,
    S_SKIDS,
    S_SNM,
    S_SFM,
    S_MISS,
    S_HIT,
    S_RCODE,
    S_RTAG,
    S_RKIDS,
    S_ANM,
    S_AFM
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [63:0] code;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] entry_offset;
    logic [63:0] tag_or_name;
    logic [63:0] attr_form;
    logic [7:0]  has_children;
    logic [16:0] next_offset;
  } result_t;

  typedef struct packed {
    logic accept;
    logic go;
    logic go_byte;
    logic mark;
    logic keep_name;
    logic keep_tag;
    logic hint_walk;
    logic range2;
    logic hit;
    logic emit_lookup;
    logic emit_attr;
    logic emit_miss;
  } cmd_t;

  typedef struct packed {
    logic f_busy;
    logic f_done;
    logic pos_ge_limit;
    logic acc_zero;
    logic acc_match;
    logic name_zero;
    logic hint_done;
    logic hint_differs;
    logic in_range2;
  } status_t;

endpackage

// ----- design/datl_ctrl.sv -----
// Controller state machine of the abbreviation table lookup block.
// Depends on datl_pkg and the assertion macro header.
`include "debug_abbrev_table_lookup_top_defines.svh"
module datl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        kind,
  input  datl_pkg::status_t status,
  output logic              busy,
  output datl_pkg::cmd_t    cmd
);
  import datl_pkg::*;

  state_t state, state_next;
  logic   fetch_st;
  logic   accept;

  assign accept = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && kind == K_LOOKUP) state_next = S_HINT;
        else if (accept && kind == K_ATTR) state_next = S_ANM;
      end
      S_HINT: if (status.hint_done) state_next = S_SCODE;
      S_SCODE: begin
        priority if (!status.f_busy && !status.f_done && status.pos_ge_limit) begin
          state_next = S_MISS;
        end else if (status.f_done) begin
          priority if (status.acc_zero) state_next = S_MISS;
          else if (status.acc_match) state_next = S_HIT;
          else state_next = S_STAG;
        end
      end
      S_STAG:  if (status.f_done) state_next = S_SKIDS;
      S_SKIDS: if (status.f_done) state_next = S_SNM;
      S_SNM:   if (status.f_done) state_next = S_SFM;
      S_SFM: begin
        if (status.f_done) begin
          state_next = (status.name_zero || status.acc_zero) ? S_SCODE : S_SNM;
        end
      end
      S_MISS: begin
        state_next = (!status.in_range2 && status.hint_differs) ? S_SCODE : S_IDLE;
      end
      S_HIT:   state_next = S_RCODE;
      S_RCODE: if (status.f_done) state_next = S_RTAG;
      S_RTAG:  if (status.f_done) state_next = S_RKIDS;
      S_RKIDS: if (status.f_done) state_next = S_IDLE;
      S_ANM:   if (status.f_done) state_next = S_AFM;
      S_AFM:   if (status.f_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    fetch_st = (state == S_SCODE) || (state == S_STAG) || (state == S_SKIDS) ||
               (state == S_SNM) || (state == S_SFM) || (state == S_RCODE) ||
               (state == S_RTAG) || (state == S_RKIDS) || (state == S_ANM) ||
               (state == S_AFM);
    cmd             = '0;
    cmd.accept      = accept;
    cmd.go          = fetch_st && !status.f_busy && !status.f_done &&
                      !((state == S_SCODE) && status.pos_ge_limit);
    cmd.go_byte     = (state == S_SKIDS) || (state == S_RKIDS);
    cmd.mark        = cmd.go && (state == S_SCODE);
    cmd.keep_name   = status.f_done && ((state == S_SNM) || (state == S_ANM));
    cmd.keep_tag    = status.f_done && (state == S_RTAG);
    cmd.hint_walk   = (state == S_HINT);
    cmd.range2      = (state == S_MISS) && !status.in_range2 && status.hint_differs;
    cmd.emit_miss   = (state == S_MISS) && !(!status.in_range2 && status.hint_differs);
    cmd.hit         = (state == S_HIT);
    cmd.emit_lookup = status.f_done && (state == S_RKIDS);
    cmd.emit_attr   = status.f_done && (state == S_AFM);
    busy            = (state != S_IDLE);
  end

  `DATL_ASSERT_IMP(a_go_unit_free, clk, rst, cmd.go, !status.f_busy && !status.f_done, "fetch started while running")
  `DATL_ASSERT_IMP(a_idle_quiet, clk, rst, state == S_IDLE, !status.f_busy, "fetch running while idle")
  `DATL_ASSERT_NEXT(a_go_runs, clk, rst, cmd.go, status.f_busy, "fetch did not start")

endmodule

// ----- design/datl_dp.sv -----
// Datapath of the abbreviation table lookup block: byte store, LEB128
// fetch unit, hint cache and result register. Depends on datl_pkg.
module datl_dp #(
  parameter int HINT_SLOTS  = datl_pkg::HINT_SLOTS_DEF,
  parameter int STORE_BYTES = datl_pkg::STORE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  datl_pkg::item_t   item,
  input  datl_pkg::cmd_t    cmd,
  input  logic              section_end_we,
  input  logic [16:0]       section_end_data,
  output datl_pkg::status_t status,
  output logic              strobe,
  output datl_pkg::result_t result
);
  import datl_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = ((AW > 17) ? AW : 17) + 1;
  localparam int SW = (HINT_SLOTS > 1) ? $clog2(HINT_SLOTS) : 1;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rdata;
  logic          oor_q;

  logic [PW-1:0] pos;
  logic [63:0]   acc;
  logic [6:0]    sh;
  logic          f_busy, f_done, phase, mode_byte;
  logic [7:0]    b;

  logic [16:0]   section_end;
  logic [15:0]   unit_start;
  logic [63:0]   want;
  logic [63:0]   nm_q, tag_q;
  logic [15:0]   hint, here;
  logic [16:0]   limit;
  logic          in_r2;

  logic [63:0]   hint_keys [HINT_SLOTS];
  logic [15:0]   hint_offs [HINT_SLOTS];
  logic          hint_valid [HINT_SLOTS];
  logic [SW-1:0] slot_tab [256];
  logic [SW-1:0] slot_q, s;
  logic [4:0]    d;

  logic          take, stop;
  logic [15:0]   hint_val;
  logic [16:0]   end_clamp, pos_cap;
  logic          load_ok;

  for (genvar i = 0; i < 256; i++) begin : g_slot
    assign slot_tab[i] = SW'(i % HINT_SLOTS);
  end

  assign load_ok   = cmd.accept && (item.kind == K_LOAD) &&
                     (32'(item.address) < 32'(STORE_BYTES));
  assign b         = oor_q ? 8'd0 : rdata;
  assign end_clamp = (section_end > 17'(OFFSET_CAP)) ? 17'(OFFSET_CAP) : section_end;
  assign pos_cap   = (pos > PW'(OFFSET_CAP)) ? 17'(OFFSET_CAP) : pos[16:0];
  assign take      = hint_valid[s] &&
                     ((s != '0) || ((d == '0) && (hint_keys[s] == want)));
  assign stop      = take || (s == '0) || (d == 5'(BACKUP_REACH - 1));
  assign hint_val  = take ? hint_offs[s] : unit_start;

  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[AW'(item.address)] <= item.data_byte;
    end
    rdata <= mem[pos[AW-1:0]];
    oor_q <= (pos >= PW'(STORE_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_busy <= 1'b0;
      f_done <= 1'b0;
      phase  <= 1'b0;
    end else begin
      f_done <= 1'b0;
      if (cmd.go) begin
        f_busy <= 1'b1;
        phase  <= 1'b0;
      end else if (f_busy) begin
        phase <= !phase;
        if (phase && (mode_byte || !b[7])) begin
          f_busy <= 1'b0;
          f_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      acc       <= '0;
      sh        <= '0;
      mode_byte <= cmd.go_byte;
    end else if (f_busy && phase) begin
      if (mode_byte) begin
        acc <= 64'(b);
      end else if (sh < 7'd64) begin
        acc <= acc | (64'(b[6:0]) << sh[5:0]);
        sh  <= sh + 7'd7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (item.kind == K_ATTR)) begin
      pos <= PW'(item.address);
    end else if (cmd.hint_walk && stop) begin
      pos <= PW'(hint_val);
    end else if (cmd.range2) begin
      pos <= PW'(unit_start);
    end else if (cmd.hit) begin
      pos <= PW'(here);
    end else if (f_busy && phase) begin
      pos <= pos + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (item.kind == K_LOOKUP)) begin
      want   <= item.code;
      slot_q <= slot_tab[item.code[7:0]];
      s      <= slot_tab[item.code[7:0]];
      d      <= '0;
    end else if (cmd.hint_walk) begin
      if (stop) begin
        hint  <= hint_val;
        limit <= end_clamp;
        in_r2 <= 1'b0;
        s     <= slot_q;
      end else begin
        s <= s - SW'(1);
        d <= d + 5'd1;
      end
    end else if (cmd.range2) begin
      limit <= 17'(hint);
      in_r2 <= 1'b1;
    end
    if (cmd.mark)      here  <= pos[15:0];
    if (cmd.keep_name) nm_q  <= acc;
    if (cmd.keep_tag)  tag_q <= acc;
  end

  always_ff @(posedge clk) begin
    if (cmd.hit && !(hint_valid[s] && (hint_offs[s] == here))) begin
      hint_keys[s] <= want;
      hint_offs[s] <= here;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section_end <= 17'(SECTION_END_RST);
      unit_start  <= '0;
      for (int i = 0; i < HINT_SLOTS; i++) hint_valid[i] <= 1'b0;
    end else begin
      if (section_end_we) section_end <= section_end_data;
      if (cmd.accept && (item.kind == K_BEGIN)) begin
        unit_start <= item.address;
        for (int i = 0; i < HINT_SLOTS; i++) hint_valid[i] <= 1'b0;
      end else if (cmd.hit) begin
        hint_valid[s] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_lookup || cmd.emit_attr || cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_lookup) begin
      result.status       <= 1'b1;
      result.entry_offset <= here;
      result.tag_or_name  <= tag_q;
      result.attr_form    <= '0;
      result.has_children <= acc[7:0];
      result.next_offset  <= pos_cap;
    end else if (cmd.emit_attr) begin
      result.status       <= (nm_q != '0);
      result.entry_offset <= '0;
      result.tag_or_name  <= nm_q;
      result.attr_form    <= acc;
      result.has_children <= '0;
      result.next_offset  <= pos_cap;
    end else if (cmd.emit_miss) begin
      result <= '0;
    end
  end

  always_comb begin
    status.f_busy       = f_busy;
    status.f_done       = f_done;
    status.pos_ge_limit = (pos >= PW'(limit));
    status.acc_zero     = (acc == '0);
    status.acc_match    = (acc == want);
    status.name_zero    = (nm_q == '0);
    status.hint_done    = stop;
    status.hint_differs = (hint != unit_start);
    status.in_range2    = in_r2;
  end

endmodule

// ----- design/debug_abbrev_table_lookup_top.sv -----
// Top level of the abbreviation table lookup block.
// Depends on datl_pkg, datl_ctrl and datl_dp.
//
// Items are taken when start is high and busy is low. Load and begin-unit
// items complete at acceptance and give no result; busy stays low. Attribute
// reads and lookups raise busy and give one result on strobe for a single
// cycle, which the receiver must take. Every store byte is read through the
// single registered read port of the byte store: an attribute read fetches
// the two LEB128 numbers at its address; a lookup walks the hint cache, scans
// records from the hint and, on a miss, from the unit start up to the hint,
// then re-reads the found record's code, tag and children byte. There is no
// clearing pass after reset.
module debug_abbrev_table_lookup_top #(
  parameter int HINT_SLOTS  = datl_pkg::HINT_SLOTS_DEF,
  parameter int STORE_BYTES = datl_pkg::STORE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  datl_pkg::item_t   item,
  input  logic              section_end_we,
  input  logic [16:0]       section_end_data,
  output logic              strobe,
  output datl_pkg::result_t result
);
  import datl_pkg::*;

  cmd_t    cmd;
  status_t status;

  datl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (item.kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  datl_dp #(
    .HINT_SLOTS  (HINT_SLOTS),
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .cmd              (cmd),
    .section_end_we   (section_end_we),
    .section_end_data (section_end_data),
    .status           (status),
    .strobe           (strobe),
    .result           (result)
  );

endmodule

// ----- tb/tb_debug_abbrev_table_lookup_top.sv -----
// Testbench for the abbreviation table lookup block: random and directed
// transactions with a scoreboard class that predicts results. Depends on
// datl_pkg and debug_abbrev_table_lookup_top.
module tb_debug_abbrev_table_lookup_top;
  import datl_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int STORE_SIZE  = 65536;

  class abbrev_scoreboard;
    logic [7:0]  mem [0:STORE_SIZE-1];
    bit          written [0:STORE_SIZE-1];
    logic [63:0] hint_key [0:15];
    logic [15:0] hint_off [0:15];
    bit          hint_ok [0:15];
    logic [15:0] unit_base;
    int unsigned sec_end;
    int unsigned rd_pos;
    bit          bad;
    result_t     pending_results [$];
    int          errors;

    function void reset_state();
      sec_end = 65536;
      unit_base = 0;
      errors = 0;
      foreach (written[i]) written[i] = 0;
      clear_hints();
    endfunction

    function void clear_hints();
      foreach (hint_ok[i]) begin
        hint_ok[i] = 0;
        hint_key[i] = 0;
        hint_off[i] = 0;
      end
    endfunction

    function void set_end(int unsigned v);
      sec_end = v;
    endfunction

    function logic [7:0] fetch_byte();
      logic [7:0] b;
      b = 0;
      if (rd_pos < STORE_SIZE) begin
        if (!written[rd_pos]) bad = 1;
        b = mem[rd_pos];
      end
      rd_pos++;
      return b;
    endfunction

    function logic [63:0] fetch_uleb();
      logic [63:0] v;
      logic [7:0]  b;
      int          sh;
      v = 0;
      sh = 0;
      do begin
        b = fetch_byte();
        if (sh < 64) begin
          v = v | ({57'd0, b[6:0]} << sh);
          sh += 7;
        end
      end while (b[7]);
      return v;
    endfunction

    function bit scan(logic [63:0] want, int unsigned from, int unsigned limit,
                      output int unsigned at);
      int unsigned here;
      logic [63:0] c, nm, fm;
      at = 0;
      rd_pos = from;
      while (rd_pos < limit && !bad) begin
        here = rd_pos;
        c = fetch_uleb();
        if (c == 0) break;
        if (c == want) begin
          at = here;
          return 1;
        end
        void'(fetch_uleb());
        void'(fetch_byte());
        do begin
          nm = fetch_uleb();
          fm = fetch_uleb();
        end while (nm != 0 && fm != 0 && !bad);
      end
      return 0;
    endfunction

    // Work out the result of one transaction; apply state changes on commit.
    // Returns 0 when the transaction would read a never-written byte.
    function bit evaluate(item_t it, bit commit, output result_t r);
      int unsigned hint, lim, pos, s, slot;
      bit          found;
      r = '0;
      bad = 0;
      case (kind_t'(it.kind))
        K_LOAD: begin
          if (commit) begin
            mem[it.address] = it.data_byte;
            written[it.address] = 1;
          end
        end
        K_BEGIN: begin
          if (commit) begin
            unit_base = it.address;
            clear_hints();
          end
        end
        K_ATTR: begin
          rd_pos = it.address;
          r.tag_or_name = fetch_uleb();
          r.attr_form = fetch_uleb();
          r.status = r.tag_or_name != 0;
          r.next_offset = rd_pos > 65536 ? 17'd65536 : rd_pos[16:0];
        end
        default: begin
          lim = sec_end > 65536 ? 65536 : sec_end;
          hint = unit_base;
          slot = it.code[3:0];
          if (hint_ok[slot] && hint_key[slot] == it.code) begin
            hint = hint_off[slot];
          end else begin
            s = slot;
            for (int d = 0; d < BACKUP_REACH && s != 0; d++) begin
              if (hint_ok[s]) begin
                hint = hint_off[s];
                break;
              end
              s--;
            end
          end
          found = scan(it.code, hint, lim, pos);
          if (!found && hint != unit_base && !bad)
            found = scan(it.code, unit_base, hint, pos);
          if (found && !bad) begin
            if (commit && !(hint_ok[slot] && hint_off[slot] == pos[15:0])) begin
              hint_key[slot] = it.code;
              hint_off[slot] = pos[15:0];
              hint_ok[slot] = 1;
            end
            rd_pos = pos;
            void'(fetch_uleb());
            r.tag_or_name = fetch_uleb();
            r.has_children = fetch_byte();
            r.status = 1;
            r.entry_offset = pos[15:0];
            r.next_offset = rd_pos > 65536 ? 17'd65536 : rd_pos[16:0];
          end
        end
      endcase
      return !bad;
    endfunction

    function bit is_safe(item_t it);
      result_t r;
      return evaluate(it, 0, r);
    endfunction

    function void note_item(item_t it);
      result_t r;
      void'(evaluate(it, 1, r));
      if (it.kind == K_LOOKUP || it.kind == K_ATTR) pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0h got %0h", e.status, got.status); errors++;
      end
      if (got.entry_offset !== e.entry_offset) begin
        $error("entry_offset exp %0h got %0h", e.entry_offset, got.entry_offset); errors++;
      end
      if (got.tag_or_name !== e.tag_or_name) begin
        $error("tag_or_name exp %0h got %0h", e.tag_or_name, got.tag_or_name); errors++;
      end
      if (got.attr_form !== e.attr_form) begin
        $error("attr_form exp %0h got %0h", e.attr_form, got.attr_form); errors++;
      end
      if (got.has_children !== e.has_children) begin
        $error("has_children exp %0h got %0h", e.has_children, got.has_children); errors++;
      end
      if (got.next_offset !== e.next_offset) begin
        $error("next_offset exp %0h got %0h", e.next_offset, got.next_offset); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  item_t       drv_item = '0;
  logic        section_end_we = 0;
  logic [16:0] section_end_data = '0;
  logic        strobe;
  result_t     result;

  abbrev_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned sec_base, sec_len;
  logic [63:0] codes [$];

  debug_abbrev_table_lookup_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(drv_item),
    .section_end_we(section_end_we), .section_end_data(section_end_data),
    .strobe(strobe), .result(result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_result(result);
  end

  task automatic send(item_t it);
    int gap;
    if ((it.kind == K_LOOKUP || it.kind == K_ATTR) && !sb.is_safe(it)) return;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    drv_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic send_kind(kind_t k, logic [15:0] a, logic [7:0] d, logic [63:0] c);
    item_t it;
    it.kind = k;
    it.address = a;
    it.data_byte = d;
    it.code = c;
    send(it);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_end(int unsigned v);
    drain();
    section_end_we <= 1;
    section_end_data <= v[16:0];
    @(posedge clk);
    section_end_we <= 0;
    sb.set_end(v);
  endtask

  function automatic void put_uleb(ref logic [7:0] q[$], input logic [63:0] v,
                                   input int pad);
    do begin
      q.push_back({(v > 127 || pad > 0), v[6:0]});
      v = v >> 7;
    end while (v != 0);
    while (pad > 0) begin
      pad--;
      q.push_back({pad > 0, 7'd0});
    end
  endfunction

  function automatic logic [63:0] pick_code();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return {32'd0, $urandom};
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Lay out a section of records, load it and open a unit at its base.
  task automatic build_section(int nrec, bit at_top);
    logic [7:0] q[$];
    int         npairs;
    logic [63:0] c;
    codes.delete();
    for (int r = 0; r < nrec; r++) begin
      c = pick_code();
      codes.push_back(c);
      put_uleb(q, c, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0);
      put_uleb(q, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : $urandom_range(1, 80), 0);
      q.push_back($urandom_range(0, 255));
      npairs = $urandom_range(0, 3);
      for (int p = 0; p < npairs; p++) begin
        put_uleb(q, $urandom_range(1, 300), 0);
        put_uleb(q, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : $urandom_range(1, 40), 0);
      end
      put_uleb(q, 0, 0);
      put_uleb(q, 0, 0);
    end
    q.push_back(8'd0);
    sec_len = q.size();
    sec_base = at_top ? STORE_SIZE - sec_len : $urandom_range(0, STORE_SIZE - sec_len);
    foreach (q[i]) send_kind(K_LOAD, sec_base + i, q[i], {$urandom, $urandom});
    send_kind(K_BEGIN, sec_base, $urandom, {$urandom, $urandom});
  endtask

  task automatic random_ops(int n);
    int done;
    int sel;
    logic [63:0] c;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_kind(K_LOOKUP, $urandom, $urandom, codes[$urandom_range(0, codes.size() - 1)]);
        done++;
      end else if (sel < 55) begin
        c = {$urandom, $urandom};
        send_kind(K_LOOKUP, $urandom, $urandom, c);
        done++;
      end else if (sel < 65) begin
        send_kind(K_LOOKUP, $urandom, $urandom, $urandom_range(0, 63));
        done++;
      end else if (sel < 90) begin
        send_kind(K_ATTR, sec_base + $urandom_range(0, sec_len - 1), $urandom,
                  {$urandom, $urandom});
        done++;
      end else if (sel < 95) begin
        send_kind(K_LOAD, $urandom, $urandom, {$urandom, $urandom});
      end else begin
        send_kind(K_BEGIN, sec_base, $urandom, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset section end, every code, misses, code zero, store edge
    build_section(5, 0);
    foreach (codes[i]) send_kind(K_LOOKUP, 0, 0, codes[i]);
    foreach (codes[i]) send_kind(K_LOOKUP, 16'hFFFF, 8'hFF, codes[i]);
    send_kind(K_LOOKUP, 0, 0, 64'd0);
    send_kind(K_LOOKUP, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_kind(K_ATTR, sec_base, 0, 0);
    send_kind(K_ATTR, sec_base + sec_len - 1, 0, 0);
    send_kind(K_LOAD, 16'hFFFF, 8'h85, 0);
    send_kind(K_ATTR, 16'hFFFF, 0, 0);
    send_kind(K_LOAD, 16'hFFFF, 8'h00, 0);
    send_kind(K_ATTR, 16'hFFFF, 0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_end(131071);
        1: write_end(0);
        2: write_end(65536);
        default: write_end($urandom_range(0, 131071));
      endcase
      build_section($urandom_range(3, 14), ph == 2);
      if (ph >= 4) write_end($urandom_range(0, 1) ? sec_base + sec_len
                                                  : sec_base + sec_len / 2);
      random_ops(90);
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- debug_abbrev_table_lookup_top.f -----
+incdir+design
design/datl_pkg.sv
design/datl_ctrl.sv
design/datl_dp.sv
design/debug_abbrev_table_lookup_top.sv
tb/tb_debug_abbrev_table_lookup_top.sv
